// File: sv/hsp_pkg.sv
// Shared types and constants for the packed handle slot pool.
// Used by hsp_ctrl, hsp_datapath and packed_handle_slot_pool_core; no dependencies.
package hsp_pkg;

    localparam int POOL_DEPTH_DEF     = 256;
    localparam int INSTANCE_WIDTH_DEF = 64;
    localparam int DATA_WIDTH_DEF     = 64;

    localparam int HANDLE_W = 8;
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [HANDLE_W-1:0] handle;
        logic [WORD_W-1:0]   instance_word;
        logic [WORD_W-1:0]   data_word;
    } in_beat_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [WORD_W-1:0]   instance_out;
        logic [WORD_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
    } out_beat_t;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic lookup;
        logic move;
        logic readout;
        logic deliver;
        logic pend_to_out;
    } dp_cmd_t;

    typedef struct packed {
        logic init_last;
        cmd_t op;
        logic live;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/hsp_ctrl.sv
// Controller state machine of the packed handle slot pool.
// Depends on hsp_pkg; drives the command struct of hsp_datapath.
module hsp_ctrl
    import hsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOKUP,
        S_MOVE,
        S_READOUT,
        S_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (stat.live && stat.op == CMD_FREE)
                begin
                    state_next = S_MOVE;
                end
                else if (stat.live && stat.op == CMD_READ)
                begin
                    state_next = S_READOUT;
                end
                else
                begin
                    cmd.deliver = 1'b1;
                    state_next  = stat.out_free ? S_IDLE : S_WAIT;
                end
            end
            S_MOVE:
            begin
                cmd.move    = 1'b1;
                cmd.deliver = 1'b1;
                state_next  = stat.out_free ? S_IDLE : S_WAIT;
            end
            S_READOUT:
            begin
                cmd.readout = 1'b1;
                cmd.deliver = 1'b1;
                state_next  = stat.out_free ? S_IDLE : S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.pend_to_out = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule

// File: sv/hsp_datapath.sv
// Datapath of the packed handle slot pool: both maps, both word stores,
// the live count and the output registers. Depends on hsp_pkg.
module hsp_datapath
    import hsp_pkg::*;
#(
    parameter int POOL_DEPTH     = POOL_DEPTH_DEF,
    parameter int INSTANCE_WIDTH = INSTANCE_WIDTH_DEF,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_beat_t  in_beat,
    output out_beat_t out_beat,
    output logic      out_valid,
    input  logic      out_stall,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat
);

    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

    logic [SLOT_W-1:0]         h2s_mem [POOL_DEPTH];
    logic [SLOT_W-1:0]         s2h_mem [POOL_DEPTH];
    logic [INSTANCE_WIDTH-1:0] inst_mem [POOL_DEPTH];
    logic [DATA_WIDTH-1:0]     data_mem [POOL_DEPTH];

    cmd_t                      op_reg;
    logic [HANDLE_W-1:0]       hnd_reg;
    logic [INSTANCE_WIDTH-1:0] iw_reg;
    logic [DATA_WIDTH-1:0]     dw_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [SLOT_W-1:0]         clr_reg;
    logic [SLOT_W-1:0]         slot_rd_reg;
    logic [SLOT_W-1:0]         moved_rd_reg;
    logic [INSTANCE_WIDTH-1:0] inst_rd_reg;
    logic [DATA_WIDTH-1:0]     data_rd_reg;
    logic [INSTANCE_WIDTH-1:0] inst_last_rd_reg;
    logic [DATA_WIDTH-1:0]     data_last_rd_reg;
    out_beat_t                 out_reg;
    out_beat_t                 pend_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [SLOT_W-1:0] in_hidx;
    logic [SLOT_W-1:0] s2h_raddr;
    logic [SLOT_W-1:0] hnd_idx;
    logic [SLOT_W-1:0] last;
    logic [SLOT_W-1:0] count_idx;
    logic              live;
    logic              full;
    logic              same;
    logic              out_free;
    out_beat_t         res;

    logic                      h2s_we;
    logic [SLOT_W-1:0]         h2s_waddr;
    logic [SLOT_W-1:0]         h2s_wdata;
    logic                      s2h_we;
    logic [SLOT_W-1:0]         s2h_waddr;
    logic [SLOT_W-1:0]         s2h_wdata;
    logic                      inst_we;
    logic [SLOT_W-1:0]         inst_waddr;
    logic [INSTANCE_WIDTH-1:0] inst_wdata;
    logic                      data_we;
    logic [SLOT_W-1:0]         data_waddr;
    logic [DATA_WIDTH-1:0]     data_wdata;

    assign in_hidx   = SLOT_W'(in_beat.handle);
    assign s2h_raddr = (cmd_t'(in_beat.cmd) == CMD_ALLOC) ? SLOT_W'(count_reg)
                                                          : SLOT_W'(count_reg - 1'b1);
    assign hnd_idx   = SLOT_W'(hnd_reg);
    assign last      = SLOT_W'(count_reg - 1'b1);
    assign count_idx = SLOT_W'(count_reg);
    assign live      = ({24'd0, hnd_reg} < 32'(POOL_DEPTH)) &&
                       (CNT_W'(slot_rd_reg) < count_reg);
    assign full      = (count_reg == CNT_W'(POOL_DEPTH));
    assign same      = (slot_rd_reg == last);
    assign out_free  = !out_valid_reg || !out_stall;

    assign stat.init_last = (clr_reg == SLOT_W'(POOL_DEPTH - 1));
    assign stat.op        = op_reg;
    assign stat.live      = live;
    assign stat.out_free  = out_free;

    always_comb
    begin
        h2s_we     = 1'b0;
        h2s_waddr  = clr_reg;
        h2s_wdata  = clr_reg;
        s2h_we     = 1'b0;
        s2h_waddr  = clr_reg;
        s2h_wdata  = clr_reg;
        inst_we    = 1'b0;
        inst_waddr = count_idx;
        inst_wdata = iw_reg;
        data_we    = 1'b0;
        data_waddr = count_idx;
        data_wdata = '0;
        if (cmd.init_wr)
        begin
            h2s_we = 1'b1;
            s2h_we = 1'b1;
        end
        if (cmd.lookup)
        begin
            if (op_reg == CMD_ALLOC && !full)
            begin
                inst_we = 1'b1;
                data_we = 1'b1;
            end
            if (op_reg == CMD_WRITE && live)
            begin
                data_we    = 1'b1;
                data_waddr = slot_rd_reg;
                data_wdata = dw_reg;
            end
            if (op_reg == CMD_FREE && live && !same)
            begin
                s2h_we    = 1'b1;
                s2h_waddr = last;
                s2h_wdata = hnd_idx;
                h2s_we    = 1'b1;
                h2s_waddr = hnd_idx;
                h2s_wdata = last;
            end
        end
        if (cmd.move && !same)
        begin
            s2h_we     = 1'b1;
            s2h_waddr  = slot_rd_reg;
            s2h_wdata  = moved_rd_reg;
            h2s_we     = 1'b1;
            h2s_waddr  = moved_rd_reg;
            h2s_wdata  = slot_rd_reg;
            inst_we    = 1'b1;
            inst_waddr = slot_rd_reg;
            inst_wdata = inst_last_rd_reg;
            data_we    = 1'b1;
            data_waddr = slot_rd_reg;
            data_wdata = data_last_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h2s_we)
        begin
            h2s_mem[h2s_waddr] <= h2s_wdata;
        end
        if (cmd.accept)
        begin
            slot_rd_reg <= h2s_mem[in_hidx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2h_we)
        begin
            s2h_mem[s2h_waddr] <= s2h_wdata;
        end
        if (cmd.accept)
        begin
            moved_rd_reg <= s2h_mem[s2h_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (inst_we)
        begin
            inst_mem[inst_waddr] <= inst_wdata;
        end
        if (cmd.lookup)
        begin
            inst_rd_reg      <= inst_mem[slot_rd_reg];
            inst_last_rd_reg <= inst_mem[last];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (cmd.lookup)
        begin
            data_rd_reg      <= data_mem[slot_rd_reg];
            data_last_rd_reg <= data_mem[last];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= cmd_t'(in_beat.cmd);
            hnd_reg <= in_beat.handle;
            iw_reg  <= in_beat.instance_word[INSTANCE_WIDTH-1:0];
            dw_reg  <= in_beat.data_word[DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        res.handle_out   = hnd_reg;
        res.instance_out = '0;
        res.data_out     = '0;
        res.status       = ST_OK;
        res.live_count   = COUNT_W'(count_reg);
        if (cmd.lookup)
        begin
            if (op_reg == CMD_ALLOC)
            begin
                if (full)
                begin
                    res.handle_out = '0;
                    res.status     = ST_FULL;
                end
                else
                begin
                    res.handle_out = HANDLE_W'(moved_rd_reg);
                    res.live_count = COUNT_W'(count_reg + 1'b1);
                end
            end
            else if (!live)
            begin
                res.status = ST_NOT_LIVE;
            end
        end
        if (cmd.move)
        begin
            res.instance_out = WORD_W'(inst_rd_reg);
            res.live_count   = COUNT_W'(count_reg - 1'b1);
        end
        if (cmd.readout)
        begin
            res.instance_out = WORD_W'(inst_rd_reg);
            res.data_out     = WORD_W'(data_rd_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.lookup && op_reg == CMD_ALLOC && !full)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.move)
        begin
            count_next = count_reg - 1'b1;
        end
        out_valid_next = out_valid_reg && out_stall;
        if ((cmd.deliver && out_free) || cmd.pend_to_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.init_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver && out_free)
        begin
            out_reg <= res;
        end
        else if (cmd.pend_to_out)
        begin
            out_reg <= pend_reg;
        end
        if (cmd.deliver && !out_free)
        begin
            pend_reg <= res;
        end
    end

    assign out_beat  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: sv/packed_handle_slot_pool_core.sv
// Top level of the packed handle slot pool: controller plus datapath.
// Depends on hsp_pkg, hsp_ctrl and hsp_datapath.
//
//   Channel   Handshake              Beat type
//   in        in_valid / in_stall    in_beat_t  (cmd, handle, instance_word, data_word)
//   out       out_valid / out_stall  out_beat_t (handle_out, instance_out, data_out,
//                                                status, live_count)
//
// A beat passes the accept step and the map lookup for alloc, write and every rejected
// command; read and free add a registered store read after the lookup. The result is
// registered into the output at the end of the map lookup, or of the store read for read
// and free. After reset both maps are loaded with identity, entry by entry, with in_stall
// high. A result that meets a stalled output waits in a holding register, and the next
// beat is taken once that register has drained into the output.
module packed_handle_slot_pool_core
    import hsp_pkg::*;
#(
    parameter int POOL_DEPTH     = POOL_DEPTH_DEF,
    parameter int INSTANCE_WIDTH = INSTANCE_WIDTH_DEF,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hsp_datapath #(
        .POOL_DEPTH     (POOL_DEPTH),
        .INSTANCE_WIDTH (INSTANCE_WIDTH),
        .DATA_WIDTH     (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_beat),
        .out_beat  (out_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: tb/sv/tb_packed_handle_slot_pool_core.sv
// Self-checking testbench for packed_handle_slot_pool_core: directed and random beats
// are checked against a behavioral pool model under varied idle and stall patterns.
// Depends on hsp_pkg and the packed_handle_slot_pool_core RTL.
module tb_packed_handle_slot_pool_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hsp_pkg::*;

    localparam int POOL_N     = POOL_DEPTH_DEF;
    localparam int GEN_VIEW   = 0;
    localparam int CHK_VIEW   = 1;
    localparam int RAND_ITEMS = 650;
    localparam int PHASE_LEN  = 170;
    localparam int MAX_PRINTS = 40;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    typedef struct packed {
        in_beat_t   beat;
        logic       hold;
        logic [6:0] idle_pct;
        logic [6:0] stall_pct;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_beat;

    logic [HANDLE_W-1:0] h2s [2][POOL_N];
    logic [HANDLE_W-1:0] s2h [2][POOL_N];
    logic [COUNT_W-1:0]  live_n [2];
    logic [WORD_W-1:0]   inst_mem [2][POOL_N];
    logic [WORD_W-1:0]   data_mem [2][POOL_N];

    pending_t  pending_q[$];
    out_beat_t pool_reply_q[$];
    int        n_queued = 0;
    int        n_errors = 0;
    int        recv_stall_pct = 0;

    packed_handle_slot_pool_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    always #4 clk = ~clk;

    function automatic out_beat_t pool_apply(input int v, input in_beat_t b);
        out_beat_t r;
        logic [HANDLE_W-1:0] slot;
        logic [HANDLE_W-1:0] last;
        logic [HANDLE_W-1:0] moved;
        logic [WORD_W-1:0]   t_inst;
        logic [WORD_W-1:0]   t_data;
        r = '0;
        r.handle_out = b.handle;
        r.status = ST_OK;
        if (b.cmd == CMD_ALLOC) begin
            if (live_n[v] >= POOL_N) begin
                r.handle_out = '0;
                r.status = ST_FULL;
            end
            else begin
                slot = live_n[v][HANDLE_W-1:0];
                r.handle_out = s2h[v][slot];
                inst_mem[v][slot] = b.instance_word;
                data_mem[v][slot] = '0;
                live_n[v] = live_n[v] + 1'b1;
            end
        end
        else if ({1'b0, h2s[v][b.handle]} >= live_n[v]) begin
            r.status = ST_NOT_LIVE;
        end
        else begin
            slot = h2s[v][b.handle];
            case (b.cmd)
                CMD_FREE:
                begin
                    last = HANDLE_W'(live_n[v] - 1'b1);
                    r.instance_out = inst_mem[v][slot];
                    if (slot != last) begin
                        moved = s2h[v][last];
                        t_inst = inst_mem[v][slot];
                        t_data = data_mem[v][slot];
                        s2h[v][last] = b.handle;
                        s2h[v][slot] = moved;
                        h2s[v][b.handle] = last;
                        h2s[v][moved] = slot;
                        inst_mem[v][slot] = inst_mem[v][last];
                        data_mem[v][slot] = data_mem[v][last];
                        inst_mem[v][last] = t_inst;
                        data_mem[v][last] = t_data;
                    end
                    live_n[v] = live_n[v] - 1'b1;
                end
                CMD_READ:
                begin
                    r.instance_out = inst_mem[v][slot];
                    r.data_out = data_mem[v][slot];
                end
                default:
                begin
                    data_mem[v][slot] = b.data_word;
                end
            endcase
        end
        r.live_count = live_n[v];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_live_handle();
        if (live_n[GEN_VIEW] == 0)
            return HANDLE_W'($urandom_range(POOL_N - 1));
        return s2h[GEN_VIEW][$urandom_range(live_n[GEN_VIEW] - 1)];
    endfunction

    task automatic queue_op(input cmd_t c, input logic [HANDLE_W-1:0] h,
                            input logic [WORD_W-1:0] iw, input logic [WORD_W-1:0] dw);
        pending_t p;
        out_beat_t unused;
        int phase;
        phase = n_queued / PHASE_LEN;
        if (phase > 3)
            phase = 3;
        p.beat.cmd = c;
        p.beat.handle = h;
        p.beat.instance_word = iw;
        p.beat.data_word = dw;
        p.hold = (n_queued == 80) || (n_queued > 0 && n_queued % PHASE_LEN == 0);
        p.idle_pct = (phase == 1) ? 7'd53 : (phase == 3) ? 7'd38 : 7'd0;
        p.stall_pct = (phase == 2) ? 7'd53 : (phase == 3) ? 7'd38 : 7'd0;
        unused = pool_apply(GEN_VIEW, p.beat);
        pending_q.push_back(p);
        n_queued++;
    endtask

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge clk)
    begin : drive_blk
        pending_t nxt;
        out_beat_t r;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                r = pool_apply(CHK_VIEW, in_beat);
                pool_reply_q.push_back(r);
            end
            if (!in_valid || !in_stall) begin
                if (pending_q.size() != 0
                    && !(pending_q[0].hold && pool_reply_q.size() != 0)
                    && $urandom_range(99) >= pending_q[0].idle_pct) begin
                    nxt = pending_q.pop_front();
                    in_beat <= nxt.beat;
                    in_valid <= 1'b1;
                    recv_stall_pct <= int'(nxt.stall_pct);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor_blk
        out_beat_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (pool_reply_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %h", out_beat));
                end
                else begin
                    want = pool_reply_q.pop_front();
                    check_field("handle_out", WORD_W'(out_beat.handle_out),
                                WORD_W'(want.handle_out));
                    check_field("instance_out", out_beat.instance_out, want.instance_out);
                    check_field("data_out", out_beat.data_out, want.data_out);
                    check_field("status", WORD_W'(out_beat.status), WORD_W'(want.status));
                    check_field("live_count", WORD_W'(out_beat.live_count),
                                WORD_W'(want.live_count));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus_blk
        traffic_mode_t mode;
        int n_rand;
        int full_hits;
        int roll;
        logic [WORD_W-1:0] ones;
        ones = '1;
        for (int v = 0; v < 2; v++) begin
            live_n[v] = '0;
            for (int i = 0; i < POOL_N; i++) begin
                h2s[v][i] = HANDLE_W'(i);
                s2h[v][i] = HANDLE_W'(i);
                inst_mem[v][i] = '0;
                data_mem[v][i] = '0;
            end
        end

        queue_op(CMD_READ, 8'd0, '0, '0);
        queue_op(CMD_FREE, 8'd255, ones, ones);
        queue_op(CMD_WRITE, 8'd7, '0, ones);
        queue_op(CMD_ALLOC, 8'd255, ones, '0);
        queue_op(CMD_ALLOC, 8'd0, '0, ones);
        queue_op(CMD_ALLOC, 8'd0, {32{2'b01}}, '0);
        queue_op(CMD_ALLOC, 8'd0, {32{2'b10}}, ones);
        queue_op(CMD_READ, 8'd0, '0, '0);
        queue_op(CMD_WRITE, 8'd1, '0, ones);
        queue_op(CMD_WRITE, 8'd2, ones, '0);
        queue_op(CMD_READ, 8'd1, '0, '0);
        queue_op(CMD_WRITE, 8'd3, '0, {32{2'b10}});
        queue_op(CMD_FREE, 8'd0, '0, '0);
        queue_op(CMD_READ, 8'd3, '0, '0);
        queue_op(CMD_READ, 8'd0, '0, '0);
        queue_op(CMD_FREE, 8'd2, '0, '0);
        queue_op(CMD_FREE, 8'd3, '0, '0);
        queue_op(CMD_READ, 8'd1, '0, '0);
        queue_op(CMD_WRITE, 8'd255, ones, ones);
        queue_op(CMD_FREE, 8'd1, '0, '0);
        queue_op(CMD_FREE, 8'd1, '0, '0);
        queue_op(CMD_ALLOC, 8'd128, rand_word(), rand_word());
        queue_op(CMD_READ, s2h[GEN_VIEW][0], '0, '0);

        mode = MODE_FILL;
        n_rand = 0;
        full_hits = 0;
        while (n_rand < RAND_ITEMS || mode != MODE_MIX) begin
            roll = $urandom_range(99);
            if (mode == MODE_FILL) begin
                if (live_n[GEN_VIEW] == POOL_N)
                    full_hits++;
                if (full_hits >= 4)
                    mode = MODE_DRAIN;
                roll = (roll < 85) ? 0 : (roll < 89) ? 1 : (roll < 94) ? 2 : (roll < 99) ? 3 : 4;
            end
            else if (mode == MODE_DRAIN) begin
                if (live_n[GEN_VIEW] == 0)
                    mode = MODE_MIX;
                roll = (roll < 5) ? 0 : (roll < 85) ? 1 : (roll < 90) ? 2 : (roll < 95) ? 3 : 4;
            end
            else begin
                roll = (roll < 30) ? 0 : (roll < 55) ? 1 : (roll < 75) ? 2 : (roll < 95) ? 3 : 4;
            end
            case (roll)
                0: queue_op(CMD_ALLOC, HANDLE_W'($urandom), rand_word(), rand_word());
                1: queue_op(CMD_FREE, pick_live_handle(), rand_word(), rand_word());
                2: queue_op(CMD_READ, pick_live_handle(), rand_word(), rand_word());
                3: queue_op(CMD_WRITE, pick_live_handle(), rand_word(), rand_word());
                default: queue_op(cmd_t'($urandom_range(3, 1)), HANDLE_W'($urandom),
                                  rand_word(), rand_word());
            endcase
            n_rand++;
        end

        while (pending_q.size() != 0 || in_valid || pool_reply_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
